FILE: sv/suks_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// suks_pkg: shared types and constants for the sorted unique key set
// Key, status and control types used by the cell chain and the top level.
// ----------------------------------------------------------------------------
package suks_pkg;

    localparam int KEY_W        = 32;
    localparam int STATUS_W     = 3;
    localparam int ENTRY_W      = 5;
    localparam int CAPACITY_DEF = 16;

    typedef logic signed [KEY_W-1:0] suks_key_t;

    // result codes
    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_DELETED   = 3'd2,
        ST_NOTFOUND  = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_FULL      = 3'd5
    } suks_status_t;

    // opcodes
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } suks_op_t;

    // control sequencer states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EVAL = 1'b1
    } suks_state_t;

    // control broadcast to every cell
    typedef struct packed {
        logic capture;    // latch compare flags against the incoming key
        logic ins_shift;  // open a slot at the insert point, shift up
        logic del_shift;  // close the slot of the match, shift down
    } suks_ctrl_t;

endpackage : suks_pkg
`default_nettype wire

FILE: sv/sorted_unique_key_set.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_unique_key_set: bounded set of signed keys kept in ascending order
// Insert / delete requests on a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Each request is handled in a capture step and an update step: in the cycle
// it is accepted every cell compares its key with the request and latches
// less-than and equal flags; then, once the output register is free, the
// equal flags are OR-reduced to find a match, all cells shift at once to open
// or close a slot, and the result goes into the output register. A new beat
// is accepted while a result still waits in the output register, but its
// update waits until that register has been taken. The store is empty after
// reset; no clearing pass is needed, occupancy follows from the key count.
// entry_count carries the low five bits of the count.
module sorted_unique_key_set #(
    parameter int CAPACITY = suks_pkg::CAPACITY_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          opcode,
    input  wire logic signed [suks_pkg::KEY_W-1:0] key,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [suks_pkg::STATUS_W-1:0]      status,
    output logic [suks_pkg::ENTRY_W-1:0]       entry_count
);
    import suks_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    suks_state_t  state_reg;
    suks_state_t  state_next;
    suks_ctrl_t   ctrl;
    logic         apply;

    logic         op_reg;
    logic         op_next;
    suks_key_t    hold_key_reg;
    suks_key_t    hold_key_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic          out_valid_reg;
    logic          out_valid_next;
    suks_status_t  status_reg;
    suks_status_t  status_next;
    logic [ENTRY_W-1:0] entry_reg;
    logic [ENTRY_W-1:0] entry_next;

    suks_key_t         cell_key [CAPACITY];
    logic [CAPACITY-1:0] cell_lt;
    logic [CAPACITY-1:0] cell_eq;
    logic              hit;
    logic              full;
    logic              empty;
    logic              do_ins;
    logic              do_del;

    // cell chain
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        suks_key_t left_key;
        suks_key_t right_key;
        logic      left_lt;
        logic      occupied;

        if (g == 0)
        begin : g_first
            assign left_key = cell_key[g];
            assign left_lt  = 1'b1;
        end
        else
        begin : g_mid
            assign left_key = cell_key[g-1];
            assign left_lt  = cell_lt[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_key = cell_key[g];
        end
        else
        begin : g_inner
            assign right_key = cell_key[g+1];
        end

        assign occupied = CW'(g) < count_reg;

        suks_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .occupied  (occupied),
            .req_key   (key),
            .new_key   (hold_key_reg),
            .left_key  (left_key),
            .right_key (right_key),
            .left_lt   (left_lt),
            .key_out   (cell_key[g]),
            .lt_out    (cell_lt[g]),
            .eq_out    (cell_eq[g])
        );
    end

    // match and occupancy
    assign hit   = |cell_eq;
    assign full  = count_reg == CW'(CAPACITY);
    assign empty = count_reg == '0;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready = 1'b0;
        apply    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_EVAL:
            begin
                apply = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // decision on the latched flags
    always_comb
    begin
        do_ins      = 1'b0;
        do_del      = 1'b0;
        count_next  = count_reg;
        status_next = status_reg;
        if (op_reg == OP_INSERT)
        begin
            priority if (hit)
            begin
                status_next = ST_DUPLICATE;
            end
            else if (full)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                status_next = ST_INSERTED;
                do_ins      = 1'b1;
                count_next  = count_reg + CW'(1);
            end
        end
        else
        begin
            priority if (empty)
            begin
                status_next = ST_EMPTY;
            end
            else if (!hit)
            begin
                status_next = ST_NOTFOUND;
            end
            else
            begin
                status_next = ST_DELETED;
                do_del      = 1'b1;
                count_next  = count_reg - CW'(1);
            end
        end
        if (!apply)
        begin
            do_ins      = 1'b0;
            do_del      = 1'b0;
            count_next  = count_reg;
            status_next = status_reg;
        end
    end

    assign ctrl.capture   = in_valid && in_ready;
    assign ctrl.ins_shift = do_ins;
    assign ctrl.del_shift = do_del;

    // request hold and output register
    always_comb
    begin
        op_next        = op_reg;
        hold_key_next  = hold_key_reg;
        if (ctrl.capture)
        begin
            op_next       = opcode;
            hold_key_next = key;
        end
        entry_next     = apply ? ENTRY_W'(count_next) : entry_reg;
        out_valid_next = apply || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        hold_key_reg <= hold_key_next;
        status_reg   <= status_next;
        entry_reg    <= entry_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry_count = entry_reg;

`ifndef SYNTH
    // count never passes the capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("key count above capacity");

    // a result waiting on a stalled output holds back the update
    a_eval_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL && out_valid_reg && !out_ready) |=> state_reg == S_EVAL)
        else $error("update applied while output stalled");

    // a successful delete drops the count by one
    a_del_count: assert property (@(posedge clk) disable iff (!rst_n)
        (apply && do_del) |=> count_reg == $past(count_reg) - CW'(1))
        else $error("delete did not decrement count");
`endif

endmodule : sorted_unique_key_set
`default_nettype wire

FILE: sv/suks_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// suks_cell: one slot of the sorted key chain
// Holds one key, compares it against the request and takes a key from its
// left or right neighbor when the chain shifts.
// ----------------------------------------------------------------------------
module suks_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire suks_pkg::suks_ctrl_t ctrl,
    input  wire logic               occupied,   // slot index below the count
    input  wire suks_pkg::suks_key_t req_key,   // key of the incoming beat
    input  wire suks_pkg::suks_key_t new_key,   // held key for the insert
    input  wire suks_pkg::suks_key_t left_key,
    input  wire suks_pkg::suks_key_t right_key,
    input  wire logic               left_lt,    // left neighbor is below the key
    output suks_pkg::suks_key_t     key_out,
    output logic                    lt_out,
    output logic                    eq_out
);
    import suks_pkg::*;

    suks_key_t key_reg;
    suks_key_t key_next;
    logic      lt_reg;
    logic      lt_next;
    logic      eq_reg;
    logic      eq_next;

    // compare flags, taken when a beat is accepted
    always_comb
    begin
        lt_next = lt_reg;
        eq_next = eq_reg;
        if (ctrl.capture)
        begin
            lt_next = occupied && (key_reg < req_key);
            eq_next = occupied && (key_reg == req_key);
        end
    end

    // slots at or above the insert / delete point move
    always_comb
    begin
        key_next = key_reg;
        if (ctrl.ins_shift && !lt_reg)
        begin
            key_next = left_lt ? new_key : left_key;
        end
        else if (ctrl.del_shift && !lt_reg)
        begin
            key_next = right_key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else
        begin
            lt_reg <= lt_next;
            eq_reg <= eq_next;
        end
    end

    // key storage, no reset
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key_out = key_reg;
    assign lt_out  = lt_reg;
    assign eq_out  = eq_reg;

endmodule : suks_cell
`default_nettype wire

FILE: tb/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb: self-checking bench for sorted_unique_key_set
// Sends insert and delete beats through a valid/ready driver, keeps its own
// sorted shadow of the key set to work out each status and entry count, and
// checks every result beat in order, in phases with and without random idling.
// ----------------------------------------------------------------------------
module tb;

    import suks_pkg::*;

    localparam int CAPACITY    = CAPACITY_DEF;
    localparam int HOLD_CYCLES = 120;
    localparam int STALL_LIMIT = 5000;
    localparam int POOL_N      = 12;
    localparam int PHASE_ITEMS = 488;

    typedef struct {
        suks_op_t  op;
        suks_key_t k;
    } key_request_t;

    typedef struct {
        suks_status_t        st;
        logic [ENTRY_W-1:0]  cnt;
    } key_result_t;

    logic                      clk         = 1'b0;
    logic                      rst_n       = 1'b0;
    logic                      in_valid    = 1'b0;
    logic                      in_ready;
    logic                      opcode      = 1'b0;
    logic signed [KEY_W-1:0]   key         = '0;
    logic                      out_valid;
    logic                      out_ready   = 1'b0;
    logic [STATUS_W-1:0]       status;
    logic [ENTRY_W-1:0]        entry_count;

    // stimulus and expectation stores
    key_request_t  op_queue[$];
    key_result_t   due_results[$];
    suks_key_t     live_candidates[$];

    // shadow of the key set, ascending
    suks_key_t     set_keys[CAPACITY];
    int            set_size = 0;

    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;
    int            hold_reqs      = 0;
    int            hold_done      = 0;
    int            hold_left      = 0;
    int            beats_in       = 0;
    int            beats_out      = 0;
    int            errors         = 0;
    int            stall_cycles   = 0;
    int            peak_size      = 0;
    int            status_tally[6];
    key_request_t  drv_req;
    key_result_t   due;
    key_result_t   exp_res;

    sorted_unique_key_set #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .key        (key),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .entry_count(entry_count)
    );

    always #5 clk = ~clk;

    // apply one request to the shadow set and return its status
    function automatic suks_status_t apply_key_op(suks_op_t op, suks_key_t k);
        int pos;
        bit hit;
        pos = 0;
        while (pos < set_size && set_keys[pos] < k)
            pos++;
        hit = (pos < set_size) && (set_keys[pos] == k);
        if (op == OP_INSERT)
        begin
            if (hit)
                return ST_DUPLICATE;
            if (set_size >= CAPACITY)
                return ST_FULL;
            for (int i = set_size; i > pos; i--)
                set_keys[i] = set_keys[i-1];
            set_keys[pos] = k;
            set_size++;
            return ST_INSERTED;
        end
        if (set_size == 0)
            return ST_EMPTY;
        if (!hit)
            return ST_NOTFOUND;
        for (int i = pos; i + 1 < set_size; i++)
            set_keys[i] = set_keys[i+1];
        set_size--;
        return ST_DELETED;
    endfunction

    // queue a request and track which keys may still be in the set
    task automatic queue_request(suks_op_t op, suks_key_t k);
        key_request_t r;
        int idx[$];
        r.op = op;
        r.k  = k;
        op_queue.push_back(r);
        idx = live_candidates.find_first_index(x) with (x == k);
        if (op == OP_INSERT && idx.size() == 0)
            live_candidates.push_back(k);
        else if (op == OP_DELETE && idx.size() != 0)
            live_candidates.delete(idx[0]);
    endtask

    // fill / drain / mixed runs over a small key pool plus fresh random keys
    task automatic queue_random(int n);
        suks_key_t pool[POOL_N];
        int        mode;
        int        run;
        int        ins_pct;
        int        pick;
        suks_key_t k;
        pool[0] = 32'sh8000_0000;
        pool[1] = 32'sh8000_0001;
        pool[2] = 32'sh7fff_ffff;
        pool[3] = 32'sh7fff_fffe;
        pool[4] = 32'sh0000_0000;
        pool[5] = 32'sh0000_0001;
        pool[6] = -32'sd1;
        pool[7] = -32'sd2;
        for (int i = 8; i < POOL_N; i++)
            pool[i] = $urandom;
        while (n > 0)
        begin
            mode = $urandom_range(2);
            run  = $urandom_range(8, 40);
            ins_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
            for (int j = 0; j < run && n > 0; j++)
            begin
                if ($urandom_range(99) < ins_pct)
                begin
                    k = ($urandom_range(99) < 65) ? pool[$urandom_range(POOL_N-1)]
                                                  : suks_key_t'($urandom);
                    queue_request(OP_INSERT, k);
                end
                else
                begin
                    pick = $urandom_range(99);
                    if (pick < 70 && live_candidates.size() != 0)
                        k = live_candidates[$urandom_range(live_candidates.size()-1)];
                    else if (pick < 90)
                        k = pool[$urandom_range(POOL_N-1)];
                    else
                        k = $urandom;
                    queue_request(OP_DELETE, k);
                end
                n--;
            end
        end
    endtask

    // wait until every queued beat has gone in and every result has come back
    task automatic drain;
        while (op_queue.size() != 0 || due_results.size() != 0)
            @(negedge clk);
    endtask

    // driver: offers beats from op_queue, predicts on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            opcode   <= OP_INSERT;
            key      <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                due.st  = apply_key_op(suks_op_t'(opcode), key);
                due.cnt = set_size[ENTRY_W-1:0];
                due_results.push_back(due);
                status_tally[int'(due.st)]++;
                if (set_size > peak_size)
                    peak_size = set_size;
                beats_in++;
            end
            if (!in_valid || in_ready)
            begin
                if (op_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    drv_req = op_queue.pop_front();
                    in_valid <= 1'b1;
                    opcode   <= drv_req.op;
                    key      <= drv_req.k;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks result beats, drives out_ready with stalls and hold-offs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                beats_out++;
                if (due_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: unexpected result beat: status %0d count %0d",
                                 status, entry_count);
                end
                else
                begin
                    exp_res = due_results.pop_front();
                    if (status !== exp_res.st || entry_count !== exp_res.cnt)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"ERROR: result %0d: status exp %0d got %0d, ",
                                      "count exp %0d got %0d"},
                                     beats_out, exp_res.st, status,
                                     exp_res.cnt, entry_count);
                    end
                end
            end
            if (hold_reqs != hold_done)
            begin
                hold_done <= hold_done + 1;
                hold_left <= HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("ERROR: no beat accepted for %0d cycles", STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty delete, extremes, duplicate, absent key, fill to full
        queue_request(OP_DELETE, 32'sd0);
        queue_request(OP_INSERT, 32'sd0);
        queue_request(OP_INSERT, 32'sh8000_0000);
        queue_request(OP_INSERT, 32'sh7fff_ffff);
        queue_request(OP_INSERT, -32'sd1);
        queue_request(OP_INSERT, 32'sd1);
        queue_request(OP_INSERT, 32'sh7fff_ffff);
        queue_request(OP_DELETE, 32'sd7);
        queue_request(OP_INSERT, 32'sh5555_5555);
        queue_request(OP_INSERT, 32'shaaaa_aaaa);
        queue_request(OP_INSERT, -32'sd2);
        queue_request(OP_INSERT, 32'sd2);
        queue_request(OP_INSERT, 32'sh8000_0001);
        queue_request(OP_INSERT, 32'sh7fff_fffe);
        queue_request(OP_INSERT, 32'sd100);
        queue_request(OP_INSERT, -32'sd100);
        queue_request(OP_INSERT, 32'sd1000);
        queue_request(OP_INSERT, -32'sd1000);
        queue_request(OP_INSERT, 32'sh1234_5678);
        queue_request(OP_INSERT, 32'sd5);
        queue_request(OP_INSERT, 32'sh8000_0000);
        queue_request(OP_DELETE, 32'sh8000_0000);
        queue_request(OP_DELETE, 32'sh7fff_ffff);
        queue_request(OP_DELETE, -32'sd1);
        drain();

        // no idling, with one long receiver hold-off while the sender keeps going
        queue_random(PHASE_ITEMS);
        repeat (5) @(negedge clk);
        hold_reqs = hold_reqs + 1;
        drain();

        // sender mostly idle
        send_idle_pct  = 84;
        recv_stall_pct = 0;
        queue_random(PHASE_ITEMS);
        drain();

        // receiver mostly stalling
        send_idle_pct  = 0;
        recv_stall_pct = 84;
        queue_random(PHASE_ITEMS);
        drain();

        // light idling on both sides
        send_idle_pct  = 17;
        recv_stall_pct = 17;
        queue_random(PHASE_ITEMS);
        drain();

        repeat (20) @(posedge clk);
        if (due_results.size() != 0)
        begin
            errors += due_results.size();
            $display("ERROR: %0d results never arrived", due_results.size());
        end

        $display("Run: %0d beats in, %0d results out, %0d mismatches, peak set size %0d",
                 beats_in, beats_out, errors, peak_size);
        $display({"Statuses: inserted %0d, duplicate %0d, deleted %0d, ",
                  "not found %0d, empty %0d, full %0d"},
                 status_tally[ST_INSERTED], status_tally[ST_DUPLICATE],
                 status_tally[ST_DELETED], status_tally[ST_NOTFOUND],
                 status_tally[ST_EMPTY], status_tally[ST_FULL]);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule : tb
`default_nettype wire
